// ===== rtl/dlst_pkg.sv =====
package dlst_pkg;

  localparam int TASK_W        = 5;
  localparam int DELTA_W       = 32;
  localparam int CMD_W         = 2;
  localparam int MAX_TASKS_DEF = 32;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_TICK   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_SPARE  = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [TASK_W-1:0]  task_req;
    logic [DELTA_W-1:0] ticks;
  } in_t;

  typedef struct packed {
    logic [TASK_W-1:0] woken_task;
    logic              last;
  } out_t;

  // One list node, stored at the address of its task number
  typedef struct packed {
    logic [DELTA_W-1:0] delta;
    logic [TASK_W-1:0]  nxt;
    logic               has_nxt;
  } node_t;

endpackage

// ===== rtl/delta_list_sleep_timer_queue.sv =====
// Sleep timer queue kept as a delta list of sleeping tasks.
// Input channel (in_valid_i / in_stall_o / in_data_i) takes one command per
// transaction: a timer tick, an add of a task with a sleep length in ticks,
// or a remove of a task. Output channel (out_valid_o / out_stall_i /
// out_data_o) delivers one transaction per task woken by a tick, in wake
// order, with last set on the final one of that tick.
// The list is a linked list in one node memory addressed by task number;
// each node holds its delta, the next task and a tail flag. Sleeping flags
// are flip-flops and decide membership and emptiness.
// Add and remove walk the list one node per cycle through the memory's
// single registered read port; an add into an empty list needs no walk.
// A tick ages the head and wakes each task whose delta reaches zero, in
// list order; a stalling receiver holds it up: the single output register
// holds a result until taken, and the walk waits on it.
// The block takes a new command only once the previous one is complete; a
// final result may still sit in the output register meanwhile.
// Reset clears the flags, empties the list and drops any pending result;
// memory contents need no clearing.
module delta_list_sleep_timer_queue
  import dlst_pkg::*;
#(
  parameter int MAX_TASKS = MAX_TASKS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  localparam int NodeDepth = (MAX_TASKS < (1 << TASK_W)) ? MAX_TASKS : (1 << TASK_W);
  localparam int AW        = (NodeDepth > 1) ? $clog2(NodeDepth) : 1;
  localparam int NodeW     = $bits(node_t);

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADD_WALK,
    S_ADD_NODE,
    S_ADD_LINK,
    S_ADD_TAIL,
    S_REM_WALK,
    S_REM_SUCC,
    S_TICK_HEAD,
    S_TICK_NEXT,
    S_TICK_LAST
  } state_e;

  state_e                 state_q, state_d;
  logic [TASK_W-1:0]      head_q, head_d;
  logic [NodeDepth-1:0]   flag_q, flag_d;
  logic [TASK_W-1:0]      cur_q, cur_d;
  logic [TASK_W-1:0]      tsk_q, tsk_d;
  logic [DELTA_W-1:0]     rem_q, rem_d;
  node_t                  prev_q, prev_d;
  logic [TASK_W-1:0]      prev_idx_q, prev_idx_d;
  logic                   has_prev_q, has_prev_d;
  logic [TASK_W-1:0]      pend_q, pend_d;
  logic                   out_valid_q, out_valid_d;
  out_t                   out_data_q, out_data_d;

  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  node_t                  ram_wdata;
  logic                   ram_re;
  logic [AW-1:0]          ram_raddr;
  logic [NodeW-1:0]       ram_rdata;
  node_t                  rd;

  logic                   empty;
  logic                   req_ok;
  logic                   out_free;
  logic [DELTA_W-1:0]     head_dec;

  dlst_ram #(
    .WIDTH (NodeW),
    .DEPTH (NodeDepth)
  ) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd       = node_t'(ram_rdata);
  assign empty    = ~|flag_q;
  assign req_ok   = 32'(in_data_i.task_req) < 32'(MAX_TASKS);
  assign out_free = !out_valid_q || !out_stall_i;
  assign head_dec = (rd.delta != '0) ? rd.delta - DELTA_W'(1) : '0;

  // Next state, memory accesses and results
  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    flag_d      = flag_q;
    cur_d       = cur_q;
    tsk_d       = tsk_q;
    rem_d       = rem_q;
    prev_d      = prev_q;
    prev_idx_d  = prev_idx_q;
    has_prev_d  = has_prev_q;
    pend_d      = pend_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = '0;
    ram_re      = 1'b0;
    ram_raddr   = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          tsk_d      = in_data_i.task_req;
          rem_d      = in_data_i.ticks;
          cur_d      = head_q;
          has_prev_d = 1'b0;
          unique case (in_data_i.command)
            CMD_TICK: begin
              if (!empty) begin
                ram_re    = 1'b1;
                ram_raddr = head_q[AW-1:0];
                state_d   = S_TICK_HEAD;
              end
            end
            CMD_ADD: begin
              if (req_ok && !flag_q[in_data_i.task_req[AW-1:0]]) begin
                if (empty) begin
                  // Sole node: becomes head and tail
                  ram_we    = 1'b1;
                  ram_waddr = in_data_i.task_req[AW-1:0];
                  ram_wdata = '{delta: in_data_i.ticks, nxt: '0, has_nxt: 1'b0};
                  head_d    = in_data_i.task_req;
                  flag_d[in_data_i.task_req[AW-1:0]] = 1'b1;
                end else begin
                  ram_re    = 1'b1;
                  ram_raddr = head_q[AW-1:0];
                  state_d   = S_ADD_WALK;
                end
              end
            end
            CMD_REMOVE: begin
              if (req_ok && flag_q[in_data_i.task_req[AW-1:0]]) begin
                flag_d[in_data_i.task_req[AW-1:0]] = 1'b0;
                ram_re    = 1'b1;
                ram_raddr = head_q[AW-1:0];
                state_d   = S_REM_WALK;
              end
            end
            default: ;
          endcase
        end
      end

      // Walk until a node's delta exceeds what remains
      S_ADD_WALK: begin
        if (rd.delta > rem_q) begin
          ram_we    = 1'b1;
          ram_waddr = cur_q[AW-1:0];
          ram_wdata = '{delta: rd.delta - rem_q, nxt: rd.nxt, has_nxt: rd.has_nxt};
          state_d   = S_ADD_NODE;
        end else begin
          rem_d      = rem_q - rd.delta;
          prev_d     = rd;
          prev_idx_d = cur_q;
          has_prev_d = 1'b1;
          if (rd.has_nxt) begin
            cur_d     = rd.nxt;
            ram_re    = 1'b1;
            ram_raddr = rd.nxt[AW-1:0];
          end else begin
            // Append after the tail
            ram_we    = 1'b1;
            ram_waddr = cur_q[AW-1:0];
            ram_wdata = '{delta: rd.delta, nxt: tsk_q, has_nxt: 1'b1};
            state_d   = S_ADD_TAIL;
          end
        end
      end

      S_ADD_NODE: begin
        ram_we    = 1'b1;
        ram_waddr = tsk_q[AW-1:0];
        ram_wdata = '{delta: rem_q, nxt: cur_q, has_nxt: 1'b1};
        if (has_prev_q) begin
          state_d = S_ADD_LINK;
        end else begin
          head_d  = tsk_q;
          flag_d[tsk_q[AW-1:0]] = 1'b1;
          state_d = S_IDLE;
        end
      end

      S_ADD_LINK: begin
        ram_we    = 1'b1;
        ram_waddr = prev_idx_q[AW-1:0];
        ram_wdata = '{delta: prev_q.delta, nxt: tsk_q, has_nxt: 1'b1};
        flag_d[tsk_q[AW-1:0]] = 1'b1;
        state_d   = S_IDLE;
      end

      S_ADD_TAIL: begin
        ram_we    = 1'b1;
        ram_waddr = tsk_q[AW-1:0];
        ram_wdata = '{delta: rem_q, nxt: '0, has_nxt: 1'b0};
        flag_d[tsk_q[AW-1:0]] = 1'b1;
        state_d   = S_IDLE;
      end

      // Walk to the node, keeping its predecessor
      S_REM_WALK: begin
        if (cur_q == tsk_q) begin
          if (has_prev_q) begin
            ram_we    = 1'b1;
            ram_waddr = prev_idx_q[AW-1:0];
            ram_wdata = '{delta: prev_q.delta, nxt: rd.nxt, has_nxt: rd.has_nxt};
          end else begin
            head_d = rd.nxt;
          end
          if (rd.has_nxt) begin
            rem_d     = rd.delta;
            cur_d     = rd.nxt;
            ram_re    = 1'b1;
            ram_raddr = rd.nxt[AW-1:0];
            state_d   = S_REM_SUCC;
          end else begin
            state_d = S_IDLE;
          end
        end else if (rd.has_nxt) begin
          prev_d     = rd;
          prev_idx_d = cur_q;
          has_prev_d = 1'b1;
          cur_d      = rd.nxt;
          ram_re     = 1'b1;
          ram_raddr  = rd.nxt[AW-1:0];
        end else begin
          state_d = S_IDLE;
        end
      end

      // Fold the removed delta into the successor
      S_REM_SUCC: begin
        ram_we    = 1'b1;
        ram_waddr = cur_q[AW-1:0];
        ram_wdata = '{delta: rd.delta + rem_q, nxt: rd.nxt, has_nxt: rd.has_nxt};
        state_d   = S_IDLE;
      end

      // Age the head; wake it when it reaches zero
      S_TICK_HEAD: begin
        if (head_dec != '0) begin
          ram_we    = 1'b1;
          ram_waddr = cur_q[AW-1:0];
          ram_wdata = '{delta: head_dec, nxt: rd.nxt, has_nxt: rd.has_nxt};
          state_d   = S_IDLE;
        end else begin
          flag_d[cur_q[AW-1:0]] = 1'b0;
          pend_d = cur_q;
          if (rd.has_nxt) begin
            head_d    = rd.nxt;
            cur_d     = rd.nxt;
            ram_re    = 1'b1;
            ram_raddr = rd.nxt[AW-1:0];
            state_d   = S_TICK_NEXT;
          end else if (out_free) begin
            out_valid_d = 1'b1;
            out_data_d  = '{woken_task: cur_q, last: 1'b1};
            state_d     = S_IDLE;
          end
        end
      end

      // Emit the pending task once the next node shows whether it is last
      S_TICK_NEXT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          if (rd.delta == '0) begin
            out_data_d = '{woken_task: pend_q, last: 1'b0};
            flag_d[cur_q[AW-1:0]] = 1'b0;
            pend_d = cur_q;
            if (rd.has_nxt) begin
              head_d    = rd.nxt;
              cur_d     = rd.nxt;
              ram_re    = 1'b1;
              ram_raddr = rd.nxt[AW-1:0];
            end else begin
              state_d = S_TICK_LAST;
            end
          end else begin
            out_data_d = '{woken_task: pend_q, last: 1'b1};
            state_d    = S_IDLE;
          end
        end
      end

      S_TICK_LAST: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = '{woken_task: pend_q, last: 1'b1};
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Hold state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      flag_q      <= '0;
      cur_q       <= '0;
      tsk_q       <= '0;
      rem_q       <= '0;
      prev_q      <= '0;
      prev_idx_q  <= '0;
      has_prev_q  <= 1'b0;
      pend_q      <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      flag_q      <= flag_d;
      cur_q       <= cur_d;
      tsk_q       <= tsk_d;
      rem_q       <= rem_d;
      prev_q      <= prev_d;
      prev_idx_q  <= prev_idx_d;
      has_prev_q  <= has_prev_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
      out_data_q  <= out_data_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== rtl/dlst_ram.sv =====
module dlst_ram
  import dlst_pkg::*;
#(
  parameter int WIDTH = $bits(node_t),
  parameter int DEPTH = MAX_TASKS_DEF,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read, held while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/dlst_chk.sv =====
module dlst_chk
  import dlst_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input out_t out_data_o
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed or dropped");

  // A result that is not the last of its tick leaves the block busy
  a_not_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.last |-> in_stall_o)
    else $error("non-final wake shown while idle");

  // New results only come from a tick in progress
  a_result_from_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared while idle");

  // Leave reset idle with nothing to deliver
  a_reset_clean: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o && !in_stall_o)
    else $error("not clean after reset");

endmodule

bind delta_list_sleep_timer_queue dlst_chk u_dlst_chk (.*);
